/* design/twc_pkg.sv */
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the text window console
// Request codes, register indexes, cell constants and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package twc_pkg;

	// request codes
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH      = 3'd4;

	// register reset values
	localparam logic [6:0] WIN_LEFT_RST   = 7'd0;
	localparam logic [4:0] WIN_TOP_RST    = 5'd0;
	localparam logic [6:0] WIN_WIDTH_RST  = 7'd80;
	localparam logic [4:0] WIN_HEIGHT_RST = 5'd25;
	localparam logic [7:0] GLYPH_RST      = 8'd32;

	// cell values
	localparam logic [15:0] ATTR_BRIGHT  = 16'h0F00;
	localparam logic [15:0] BLANK_CELL   = 16'h0020;
	localparam logic [7:0]  NEWLINE_CODE = 8'd10;

	// controller to datapath commands
	typedef struct packed {
		logic capture;       // latch the request fields
		logic cnt_clr;       // clear the window sweep counters
		logic init_wr;       // zero one cell of the power-up clearing pass
		logic put_wr;        // write char or blank at cursor, step cursor
		logic sweep_scroll;  // one cell of the scroll sweep
		logic sweep_clear;   // one cell of the window clear sweep
		logic glyph_wr;      // draw the cursor glyph
		logic home;          // cursor to window origin
		logic read_issue;    // read the requested screen cell
		logic out_load;      // load the result register
	} twc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scroll_now;    // the pending put moves the cursor past the bottom
		logic win_empty;     // zero window width or height
		logic sweep_last;    // sweep counters at the last window cell
		logic init_last;     // clearing pass at the last memory entry
		logic out_free;      // result register can take a result this cycle
	} twc_sts_t;

endpackage

/* design/twc_ram.sv */
// ----------------------------------------------------------------------------
// twc_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module twc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/twc_ctrl.sv */
// ----------------------------------------------------------------------------
// twc_ctrl: request sequencer of the text window console
// Runs the power-up clearing pass, then steps each request through its
// write, read, sweep and result states.
// ----------------------------------------------------------------------------
module twc_ctrl import twc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [1:0] in_req_type,
	input  twc_sts_t  sts,
	output logic      in_stall,
	output twc_cmd_t  cmd
);

	localparam logic [3:0] ST_INIT      = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_PUT_WR    = 4'd2;
	localparam logic [3:0] ST_SCROLL    = 4'd3;
	localparam logic [3:0] ST_GLYPH     = 4'd4;
	localparam logic [3:0] ST_READ      = 4'd5;
	localparam logic [3:0] ST_CLR_START = 4'd6;
	localparam logic [3:0] ST_CLEAR     = 4'd7;
	localparam logic [3:0] ST_DONE      = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// requests are taken only when idle
	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.cnt_clr = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_req_type)
						REQ_PUT:   state_nxt = ST_PUT_WR;
						REQ_READ:  state_nxt = ST_READ;
						REQ_CLEAR: state_nxt = ST_CLR_START;
						default:   state_nxt = ST_DONE;
					endcase
				end
			end
			ST_PUT_WR: begin
				cmd.put_wr = 1'b1;
				if (sts.scroll_now && !sts.win_empty) begin
					state_nxt = ST_SCROLL;
				end else begin
					state_nxt = ST_GLYPH;
				end
			end
			ST_SCROLL: begin
				cmd.sweep_scroll = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = ST_GLYPH;
				end
			end
			ST_GLYPH: begin
				cmd.glyph_wr = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_READ: begin
				cmd.read_issue = 1'b1;
				state_nxt      = ST_DONE;
			end
			ST_CLR_START: begin
				cmd.home = 1'b1;
				if (sts.win_empty) begin
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.sweep_clear = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* design/twc_dpath.sv */
// ----------------------------------------------------------------------------
// twc_dpath: datapath of the text window console
// Window registers, cursor, sweep counters, the screen memory with its
// one-stage write pipe, and the result register.
// ----------------------------------------------------------------------------
module twc_dpath import twc_pkg::*; #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  twc_cmd_t              cmd,
	output twc_sts_t              sts,
	input  logic [1:0]            req_type,
	input  logic [7:0]            char_code,
	input  logic [4:0]            read_row,
	input  logic [6:0]            read_col,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [15:0]           cell_word,
	output logic [6:0]            cursor_col_out,
	output logic [4:0]            cursor_row_out
);

	localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [8:0] COLS_L = 9'(SCREEN_COLS);
	localparam logic [7:0] ROWS_L = 8'(SCREEN_ROWS);

	// screen cell address of an in-range absolute position
	function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [7:0] c);
		return AW'(r) * AW'(SCREEN_COLS) + AW'(c);
	endfunction

	// position lies on the screen
	function automatic logic on_screen(input logic [5:0] r, input logic [7:0] c);
		return ({2'b00, r} < ROWS_L) && ({1'b0, c} < COLS_L);
	endfunction

	logic [6:0]  win_left_q;
	logic [4:0]  win_top_q;
	logic [6:0]  win_width_q;
	logic [4:0]  win_height_q;
	logic [7:0]  glyph_q;

	logic [1:0]  req_q;
	logic [7:0]  char_q;
	logic [4:0]  rrow_q;
	logic [6:0]  rcol_q;

	logic [6:0]  cur_col_q;
	logic [4:0]  cur_row_q;
	logic [4:0]  sw_row_q;
	logic [6:0]  sw_col_q;
	logic [AW-1:0] init_addr_q;
	logic        rd_ok_q;

	logic          wr_en_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [15:0]   wr_val_s1;
	logic          wr_mem_s1;
	logic          src_ok_s1;

	logic          byp_q;
	logic [15:0]   byp_val_q;
	logic [15:0]   rd_word;

	logic          out_valid_q;
	logic [15:0]   cell_word_q;
	logic [6:0]    col_out_q;
	logic [4:0]    row_out_q;

	logic [7:0]  col_inc;
	logic [7:0]  col_nxt;
	logic [5:0]  row_nxt;
	logic        scroll_now;
	logic        win_empty;
	logic        last_row;
	logic        last_col;

	logic [4:0]  dst_wrow;
	logic [6:0]  dst_wcol;
	logic [5:0]  dst_row;
	logic [7:0]  dst_col;
	logic        dst_ok;
	logic [5:0]  src_row;
	logic [7:0]  src_col;
	logic        src_ok;
	logic        rreq_ok;

	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	logic [15:0]   ram_wdata;

	// cursor step of a put: newline, advance, wrap
	always_comb begin
		col_inc = {1'b0, cur_col_q} + 8'd1;
		if (char_q == NEWLINE_CODE) begin
			col_nxt = 8'd0;
			row_nxt = {1'b0, cur_row_q} + 6'd1;
		end else if (col_inc >= {1'b0, win_width_q}) begin
			col_nxt = 8'd0;
			row_nxt = {1'b0, cur_row_q} + 6'd1;
		end else begin
			col_nxt = col_inc;
			row_nxt = {1'b0, cur_row_q};
		end
		scroll_now = (row_nxt >= {1'b0, win_height_q});
	end

	assign win_empty = (win_width_q == 7'd0) || (win_height_q == 5'd0);
	assign last_row  = (sw_row_q == win_height_q - 5'd1);
	assign last_col  = (sw_col_q == win_width_q - 7'd1);

	// destination cell in window and screen coordinates
	always_comb begin
		if (cmd.sweep_scroll || cmd.sweep_clear) begin
			dst_wrow = sw_row_q;
			dst_wcol = sw_col_q;
		end else begin
			dst_wrow = cur_row_q;
			dst_wcol = cur_col_q;
		end
		dst_row = {1'b0, win_top_q} + {1'b0, dst_wrow};
		dst_col = {1'b0, win_left_q} + {1'b0, dst_wcol};
		dst_ok  = on_screen(dst_row, dst_col);
	end

	// scroll source is one row below the destination
	assign src_row = {1'b0, win_top_q} + {1'b0, sw_row_q} + 6'd1;
	assign src_col = {1'b0, win_left_q} + {1'b0, sw_col_q};
	assign src_ok  = on_screen(src_row, src_col);
	assign rreq_ok = on_screen({1'b0, rrow_q}, {1'b0, rcol_q});

	// memory read port: requested cell or scroll source
	assign ram_re    = cmd.read_issue || cmd.sweep_scroll;
	assign ram_raddr = cmd.read_issue ? cell_addr({1'b0, rrow_q}, {1'b0, rcol_q})
	                                  : cell_addr(src_row, src_col);

	// a write landing on the cell being read is forwarded to the read data
	always_ff @(posedge clk) begin
		if (ram_re) begin
			byp_q     <= wr_en_s1 && (wr_addr_s1 == ram_raddr);
			byp_val_q <= ram_wdata;
		end
	end

	assign rd_word = byp_q ? byp_val_q : ram_rdata;

	// memory write port fed from the write stage
	assign ram_wdata = wr_mem_s1 ? (src_ok_s1 ? rd_word : 16'h0000) : wr_val_s1;

	twc_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_screen (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (wr_addr_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// write stage: one write per cycle, data from memory for scroll copies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.init_wr ||
			            ((cmd.put_wr || cmd.glyph_wr || cmd.sweep_scroll || cmd.sweep_clear)
			             && dst_ok);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cmd.init_wr ? init_addr_q : cell_addr(dst_row, dst_col);
		src_ok_s1  <= src_ok;
		wr_mem_s1  <= cmd.sweep_scroll && !last_row;
		if (cmd.put_wr) begin
			wr_val_s1 <= (char_q == NEWLINE_CODE) ? BLANK_CELL : (ATTR_BRIGHT | {8'h00, char_q});
		end else if (cmd.glyph_wr) begin
			wr_val_s1 <= ATTR_BRIGHT | {8'h00, glyph_q};
		end else if (cmd.sweep_scroll) begin
			wr_val_s1 <= BLANK_CELL;
		end else begin
			wr_val_s1 <= 16'h0000;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= WIN_LEFT_RST;
			win_top_q    <= WIN_TOP_RST;
			win_width_q  <= WIN_WIDTH_RST;
			win_height_q <= WIN_HEIGHT_RST;
			glyph_q      <= GLYPH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WIN_LEFT:   win_left_q   <= cfg_data[6:0];
				CFG_WIN_TOP:    win_top_q    <= cfg_data[4:0];
				CFG_WIN_WIDTH:  win_width_q  <= cfg_data[6:0];
				CFG_WIN_HEIGHT: win_height_q <= cfg_data[4:0];
				CFG_GLYPH:      glyph_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request fields held for the whole request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			char_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
	end

	// cursor, sweep counters and clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= 7'd0;
			cur_row_q   <= 5'd0;
			sw_row_q    <= 5'd0;
			sw_col_q    <= 7'd0;
			init_addr_q <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (cmd.put_wr) begin
				if (scroll_now) begin
					cur_col_q <= 7'd0;
					cur_row_q <= (win_height_q != 5'd0) ? win_height_q - 5'd1 : 5'd0;
				end else begin
					cur_col_q <= col_nxt[6:0];
					cur_row_q <= row_nxt[4:0];
				end
			end else if (cmd.home) begin
				cur_col_q <= 7'd0;
				cur_row_q <= 5'd0;
			end

			if (cmd.cnt_clr) begin
				sw_row_q <= 5'd0;
				sw_col_q <= 7'd0;
			end else if (cmd.sweep_scroll || cmd.sweep_clear) begin
				if (last_col) begin
					sw_col_q <= 7'd0;
					sw_row_q <= sw_row_q + 5'd1;
				end else begin
					sw_col_q <= sw_col_q + 7'd1;
				end
			end

			if (cmd.init_wr) begin
				init_addr_q <= init_addr_q + AW'(1);
			end

			if (cmd.read_issue) begin
				rd_ok_q <= rreq_ok;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_word_q <= ((req_q == REQ_READ) && rd_ok_q) ? rd_word : 16'h0000;
			col_out_q   <= cur_col_q;
			row_out_q   <= cur_row_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_word      = cell_word_q;
	assign cursor_col_out = col_out_q;
	assign cursor_row_out = row_out_q;

	// status to the controller
	always_comb begin
		sts.scroll_now = scroll_now;
		sts.win_empty  = win_empty;
		sts.sweep_last = last_row && last_col;
		sts.init_last  = (init_addr_q == AW'(DEPTH - 1));
		sts.out_free   = !out_valid_q || !out_stall;
	end

endmodule

/* design/text_window_console.sv */
// ----------------------------------------------------------------------------
// text_window_console: text-mode console engine with a configurable window
// Put, read and clear requests over a screen of 16-bit character cells.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on in_valid / in_stall; one result leaves per request on
//   out_valid / out_stall. A transfer happens at a clock edge with valid high
//   and stall low. Window and glyph registers are written through cfg_wr_en,
//   cfg_index and cfg_data while no request is in progress. The block itself
//   does not enforce this. A put writes its cell, scrolls a non-empty window
//   up one row when the cursor passes the bottom, then draws the cursor glyph;
//   a read reads the requested cell; a clear homes the cursor and clears the
//   window unless it is empty. The screen memory has one write and one read
//   port, so every sweep moves one cell a cycle; a request is taken only once
//   the one before has loaded its result.
//   After reset the block zeroes all SCREEN_COLS*SCREEN_ROWS screen cells
//   (2000 at the default size) with in_stall high; configuration writes
//   are taken during that time.
//   A result waits in the output register while out_stall is high; the next
//   request is accepted meanwhile and completes once the register is free.
// ----------------------------------------------------------------------------
module text_window_console import twc_pkg::*; #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [7:0]            char_code,
	input  logic [4:0]            read_row,
	input  logic [6:0]            read_col,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           cell_word,
	output logic [6:0]            cursor_col_out,
	output logic [4:0]            cursor_row_out
);

	twc_cmd_t cmd;
	twc_sts_t sts;

	// request sequencer
	twc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (req_type),
		.sts         (sts),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	// registers, cursor and screen memory
	twc_dpath #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.char_code      (char_code),
		.read_row       (read_row),
		.read_col       (read_col),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.cell_word      (cell_word),
		.cursor_col_out (cursor_col_out),
		.cursor_row_out (cursor_row_out)
	);

	// a request transfer always leaves the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> in_stall)
		else $error("requests still taken right after a transfer");

	// a new result is only produced while requests are held off
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	// the cursor always stays inside the largest window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_row_out != 5'd31) && (cursor_col_out != 7'd127))
		else $error("cursor outside any window");

endmodule

/* bench/text_window_console_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_console_test: self-checking bench for the text window console
// Drives put, read, clear and unused requests through the valid/stall input
// channel and checks every result against a cycle-free shadow of the screen,
// the cursor and the window registers. Window settings change between
// phases: default, partly off-screen, empty, full size and random windows.
// ----------------------------------------------------------------------------
module text_window_console_test;
	import twc_pkg::*;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
		logic       drain;   // hold off until every result is back
	} console_req_t;

	typedef struct packed {
		logic [15:0] cell_val;
		logic [6:0]  col;
		logic [4:0]  row;
	} console_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type = '0;
	logic [7:0]            char_code = '0;
	logic [4:0]            read_row = '0;
	logic [6:0]            read_col = '0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [15:0]           cell_word;
	logic [6:0]            cursor_col_out;
	logic [4:0]            cursor_row_out;

	// shadow of the screen, cursor and window registers
	logic [15:0] shadow_cells [SCREEN_COLS*SCREEN_ROWS] = '{default: '0};
	int          cur_col = 0;
	int          cur_row = 0;
	int          win_left = WIN_LEFT_RST;
	int          win_top = WIN_TOP_RST;
	int          win_width = WIN_WIDTH_RST;
	int          win_height = WIN_HEIGHT_RST;
	logic [7:0]  glyph = GLYPH_RST;

	console_req_t    pending_reqs [$];
	console_report_t reports_due [$];
	console_req_t    bus_req;
	int              items_issued = 0;
	int              accepted_items = 0;
	int              results_seen = 0;
	int              errors = 0;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              kind_count [4] = '{default: 0};
	int              scroll_count = 0;
	int              window_settings = 0;

	text_window_console #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.char_code(char_code),
		.read_row(read_row),
		.read_col(read_col),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_word(cell_word),
		.cursor_col_out(cursor_col_out),
		.cursor_row_out(cursor_row_out)
	);

	// clock and reset
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// screen access with off-screen cells ignored on write and zero on read
	function automatic void window_put(int wrow, int wcol, logic [15:0] v);
		int r, c;
		r = win_top + wrow;
		c = win_left + wcol;
		if (r < SCREEN_ROWS && c < SCREEN_COLS)
			shadow_cells[r*SCREEN_COLS + c] = v;
	endfunction

	function automatic logic [15:0] cell_get(int r, int c);
		if (r < SCREEN_ROWS && c < SCREEN_COLS)
			return shadow_cells[r*SCREEN_COLS + c];
		return '0;
	endfunction

	// apply one request to the shadow console, return the cell and cursor
	function automatic console_report_t run_console_request(console_req_t rq);
		console_report_t rep;
		int i, j;
		rep.cell_val = '0;
		case (rq.req)
			REQ_PUT: begin
				window_put(cur_row, cur_col, BLANK_CELL);
				if (rq.ch == NEWLINE_CODE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					window_put(cur_row, cur_col, ATTR_BRIGHT | {8'h00, rq.ch});
					cur_col++;
					if (cur_col >= win_width) begin
						cur_col = 0;
						cur_row++;
					end
				end
				// scroll the window up one row
				if (cur_row >= win_height) begin
					scroll_count++;
					for (i = 0; i < win_height; i++)
						for (j = 0; j < win_width; j++)
							window_put(i, j, (i + 1 == win_height) ? BLANK_CELL :
								cell_get(win_top + i + 1, win_left + j));
					cur_col = 0;
					cur_row = (win_height > 0) ? win_height - 1 : 0;
				end
				window_put(cur_row, cur_col, ATTR_BRIGHT | {8'h00, glyph});
			end
			REQ_READ: begin
				rep.cell_val = cell_get(rq.row, rq.col);
			end
			REQ_CLEAR: begin
				for (i = 0; i < win_height; i++)
					for (j = 0; j < win_width; j++)
						window_put(i, j, '0);
				cur_col = 0;
				cur_row = 0;
			end
			default: ;
		endcase
		cur_col &= 'h7F;
		cur_row &= 'h1F;
		rep.col = cur_col[6:0];
		rep.row = cur_row[4:0];
		return rep;
	endfunction

	function automatic void add_request(logic [1:0] req, logic [7:0] ch, logic [4:0] row,
	                                    logic [6:0] col, logic drain);
		console_req_t rq;
		rq.req = req;
		rq.ch = ch;
		rq.row = row;
		rq.col = col;
		rq.drain = drain;
		pending_reqs.push_back(rq);
		items_issued++;
	endfunction

	// mostly text with newlines, then reads biased to the window, rare clears
	task automatic queue_random_requests(int n);
		int pick;
		logic [1:0] req;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
		repeat (n) begin
			pick = $urandom_range(99);
			ch = 8'($urandom_range(255));
			row = 5'($urandom_range(31));
			col = 7'($urandom_range(127));
			if (pick < 70) begin
				req = REQ_PUT;
				if ($urandom_range(99) < 15)
					ch = NEWLINE_CODE;
				else if ($urandom_range(99) < 60)
					ch = 8'($urandom_range(126, 32));
			end else if (pick < 92) begin
				req = REQ_READ;
				case ($urandom_range(2))
					0: begin
						row = 5'(win_top + $urandom_range(win_height));
						col = 7'(win_left + $urandom_range(win_width));
					end
					1: begin
						row = 5'($urandom_range(SCREEN_ROWS - 1));
						col = 7'($urandom_range(SCREEN_COLS - 1));
					end
					default: ;
				endcase
			end else if (pick < 96) begin
				req = REQ_CLEAR;
			end else begin
				req = REQ_UNUSED;
			end
			add_request(req, ch, row, col, $urandom_range(99) == 0);
		end
	endtask

	// register writes, only while the console is idle
	task automatic set_window(logic [7:0] left, logic [7:0] top, logic [7:0] width,
	                          logic [7:0] height, logic [7:0] glyph_code);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WIN_LEFT;
		cfg_data <= left;
		@(posedge clk);
		cfg_index <= CFG_WIN_TOP;
		cfg_data <= top;
		@(posedge clk);
		cfg_index <= CFG_WIN_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		cfg_index <= CFG_WIN_HEIGHT;
		cfg_data <= height;
		@(posedge clk);
		cfg_index <= CFG_GLYPH;
		cfg_data <= glyph_code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_left = left[6:0];
		win_top = top[4:0];
		win_width = width[6:0];
		win_height = height[4:0];
		glyph = glyph_code;
		window_settings++;
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || results_seen != items_issued)
			@(posedge clk);
		@(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				reports_due.push_back(run_console_request(bus_req));
				kind_count[bus_req.req]++;
				accepted_items++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(pending_reqs[0].drain && results_seen != accepted_items)) begin
					bus_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= bus_req.req;
					char_code <= bus_req.ch;
					read_row <= bus_req.row;
					read_col <= bus_req.col;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_watch
		console_report_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (reports_due.size() == 0) begin
					$display("%0t: result with none outstanding, expected none, actual cell %h col %0d row %0d",
						$realtime, cell_word, cursor_col_out, cursor_row_out);
					errors++;
				end else begin
					want = reports_due.pop_front();
					if (cell_word !== want.cell_val || cursor_col_out !== want.col ||
					    cursor_row_out !== want.row) begin
						$display("%0t: mismatch, expected cell %h col %0d row %0d, actual cell %h col %0d row %0d",
							$realtime, want.cell_val, want.col, want.row,
							cell_word, cursor_col_out, cursor_row_out);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// stimulus
	initial begin
		int n;
		int l, t, w, h;
		logic [7:0] dl, dt, dw, dh;

		wait (arst_n);
		@(posedge clk);
		send_idle_pct <= 6;
		recv_stall_pct <= 87;

		// reset window: corner reads, off-screen read, char extremes, newline, unused code
		add_request(REQ_READ, 8'h00, 5'd0, 7'd0, 1'b0);
		add_request(REQ_READ, 8'h00, 5'd24, 7'd79, 1'b0);
		add_request(REQ_READ, 8'hFF, 5'd31, 7'd127, 1'b0);
		add_request(REQ_PUT, 8'h48, 5'd0, 7'd0, 1'b0);
		add_request(REQ_PUT, 8'hFF, 5'd31, 7'd127, 1'b0);
		add_request(REQ_PUT, 8'h00, 5'd0, 7'd0, 1'b0);
		add_request(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0);
		add_request(REQ_UNUSED, 8'hA5, 5'd3, 7'd5, 1'b0);
		add_request(REQ_READ, 8'h00, 5'd0, 7'd0, 1'b0);
		wait_drained();

		// window hanging off the bottom right corner: wrap, then scroll
		set_window(8'd76, 8'd22, 8'd6, 8'd4, 8'hFF);
		for (int k = 0; k < 6; k++)
			add_request(REQ_PUT, 8'(8'h41 + k), 5'd0, 7'd0, 1'b0);
		repeat (3) add_request(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0);
		add_request(REQ_READ, 8'h00, 5'd22, 7'd76, 1'b0);
		add_request(REQ_READ, 8'h00, 5'd24, 7'd79, 1'b0);
		wait_drained();

		// empty window with the cursor left beyond it
		set_window(8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
		add_request(REQ_PUT, 8'h41, 5'd0, 7'd0, 1'b0);
		add_request(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0);
		add_request(REQ_READ, 8'h00, 5'd0, 7'd0, 1'b0);
		add_request(REQ_CLEAR, 8'h00, 5'd0, 7'd0, 1'b0);

		// random phases; the slow 127 x 31 windows get few requests
		for (int ph = 0; ph < 14; ph++) begin
			wait_drained();
			if (ph == 5) begin
				send_idle_pct <= 87;
				recv_stall_pct <= 6;
			end else if (ph == 10) begin
				send_idle_pct <= 0;
				recv_stall_pct <= 0;
			end
			n = 125;
			case (ph)
				3: begin
					set_window(8'(WIN_LEFT_RST), 8'(WIN_TOP_RST), 8'(WIN_WIDTH_RST),
						8'(WIN_HEIGHT_RST), 8'($urandom_range(255)));
					n = 100;
				end
				8: begin
					set_window(8'd0, 8'd0, 8'd127, 8'd31, 8'($urandom_range(255)));
					n = 30;
				end
				12: begin
					set_window(8'd127, 8'd31, 8'd127, 8'd31, 8'($urandom_range(255)));
					n = 30;
				end
				default: begin
					case ($urandom_range(3))
						0, 1: begin
							w = $urandom_range(1, 12);
							h = $urandom_range(1, 6);
							l = $urandom_range(SCREEN_COLS - w);
							t = $urandom_range(SCREEN_ROWS - h);
						end
						2: begin
							w = $urandom_range(16);
							h = $urandom_range(8);
							l = $urandom_range(127);
							t = $urandom_range(31);
						end
						default: begin
							w = $urandom_range(1, SCREEN_COLS);
							h = $urandom_range(1, 3);
							l = $urandom_range(SCREEN_COLS - w);
							t = $urandom_range(SCREEN_ROWS - h);
						end
					endcase
					// unused upper data bits get junk
					dl = 8'(l);
					dl[7] = 1'($urandom_range(1));
					dt = 8'(t);
					dt[7:5] = 3'($urandom_range(7));
					dw = 8'(w);
					dw[7] = 1'($urandom_range(1));
					dh = 8'(h);
					dh[7:5] = 3'($urandom_range(7));
					set_window(dl, dt, dw, dh, 8'($urandom_range(255)));
				end
			endcase
			queue_random_requests(n);
		end

		wait_drained();
		repeat (50) @(posedge clk);
		$display("covered %0d requests: %0d puts, %0d reads, %0d clears, %0d unused codes",
			accepted_items, kind_count[REQ_PUT], kind_count[REQ_READ],
			kind_count[REQ_CLEAR], kind_count[REQ_UNUSED]);
		$display("%0d scrolls over %0d window settings, %0d errors",
			scroll_count, window_settings, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
